>>> rtl/brm_pkg.sv
package brm_pkg;

    localparam int MAX_BLOCK   = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_BITS    = 13;
    localparam int SUM_BITS    = 42;
    localparam int RMS_BITS    = 16;
    localparam int MAG_BITS    = SAMPLE_BITS + 1;
    localparam int SQ_BITS     = 2 * MAG_BITS;
    localparam int ROOT_BITS   = SUM_BITS / 2;
    localparam int REM_BITS    = ROOT_BITS + 2;
    localparam int STEP_BITS   = 6;

    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(735);
    localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(MAX_BLOCK);

    localparam logic [STEP_BITS-1:0] MUL_LAST  = STEP_BITS'(MAG_BITS - 1);
    localparam logic [STEP_BITS-1:0] ACC_LAST  = STEP_BITS'(SUM_BITS - 1);
    localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(SUM_BITS - 1);
    localparam logic [STEP_BITS-1:0] SQRT_LAST = STEP_BITS'(ROOT_BITS - 1);

    // Handshake between the accumulator sequencer and the divide/root unit.
    typedef struct packed {
        logic start;
        logic ack;
    } brm_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } brm_rsp_t;

endpackage

>>> rtl/brm_root.sv
module brm_root
    import brm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  brm_req_t             req,
    output brm_rsp_t             rsp,
    input  logic [SUM_BITS-1:0]  sum,
    input  logic [LEN_BITS-1:0]  len,
    output logic [RMS_BITS-1:0]  root
);

    typedef enum logic [3:0] {
        RT_IDLE = 4'b0001,
        RT_DIV  = 4'b0010,
        RT_SQRT = 4'b0100,
        RT_DONE = 4'b1000
    } rt_state_t;

    rt_state_t               state_reg, state_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;
    logic [SUM_BITS-1:0]     work_reg, work_next;
    logic [LEN_BITS-1:0]     len_reg, len_next;
    logic [LEN_BITS-1:0]     drem_reg, drem_next;
    logic [ROOT_BITS-1:0]    q_reg, q_next;
    logic [REM_BITS-1:0]     r_reg, r_next;

    // One quotient bit per cycle: shift in the next dividend bit, try the length.
    logic [LEN_BITS:0]       drem_sh;
    logic [LEN_BITS:0]       drem_sub;
    logic                    dge;
    // One root bit per cycle: bring down a pair of radicand bits, try 4q+1.
    logic [REM_BITS+1:0]     r_sh;
    logic [REM_BITS+1:0]     r_try;
    logic [REM_BITS+1:0]     r_sub;
    logic                    rge;

    always_comb begin
        drem_sh  = {drem_reg, work_reg[SUM_BITS-1]};
        drem_sub = drem_sh - {1'b0, len_reg};
        dge      = (drem_sh >= {1'b0, len_reg});
        r_sh     = {r_reg, work_reg[SUM_BITS-1 -: 2]};
        r_try    = {2'b00, q_reg, 2'b01};
        r_sub    = r_sh - r_try;
        rge      = (r_sh >= r_try);
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        work_next  = work_reg;
        len_next   = len_reg;
        drem_next  = drem_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        case (state_reg)
            RT_IDLE: begin
                if (req.start) begin
                    work_next  = sum;
                    len_next   = len;
                    drem_next  = '0;
                    step_next  = '0;
                    state_next = RT_DIV;
                end
            end
            RT_DIV: begin
                drem_next = dge ? drem_sub[LEN_BITS-1:0] : drem_sh[LEN_BITS-1:0];
                work_next = {work_reg[SUM_BITS-2:0], dge};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST) begin
                    step_next  = '0;
                    q_next     = '0;
                    r_next     = '0;
                    state_next = RT_SQRT;
                end
            end
            RT_SQRT: begin
                r_next    = rge ? r_sub[REM_BITS-1:0] : r_sh[REM_BITS-1:0];
                q_next    = {q_reg[ROOT_BITS-2:0], rge};
                work_next = {work_reg[SUM_BITS-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == SQRT_LAST) begin
                    state_next = RT_DONE;
                end
            end
            RT_DONE: begin
                if (req.ack) begin
                    state_next = RT_IDLE;
                end
            end
            default: begin
                state_next = RT_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RT_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
        work_reg <= work_next;
        len_reg  <= len_next;
        drem_reg <= drem_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
    end

    assign rsp.busy = (state_reg != RT_IDLE);
    assign rsp.done = (state_reg == RT_DONE);
    assign root     = q_reg[RMS_BITS-1:0];

endmodule

>>> rtl/block_rms_meter.sv
// Channel   Direction  Handshake           Payload
// --------  ---------  ------------------  ---------------------------------
// sample    in         s_valid / s_ready   s_sample   (16 bit, signed Q1.15)
// rms       out        m_valid / m_ready   m_rms      (16 bit, unsigned)
// config    in         cfg_wr_en           cfg_wr_data (13 bit block length)
//
// After a sample is accepted, s_ready stays low while it passes through the serial
// squarer, the bit-serial accumulator and the check step, so a new sample is taken
// only once the last one has passed the check.
// A sample that closes a block adds a hand-off state. The divide/root unit then
// works out 42 quotient bits, then 21 root bits, and hands the result to the
// output register that drives m_valid.
// Reset (synchronous, aresetn low) clears the sum, the count and all control,
// and loads the block length with 735.
// A result waits in the output register, and the next sample is taken meanwhile.
// A later block end waits in the check step until the root unit has finished and
// handed its result on. With a block length of one, the root unit sets the pace
// of the block ends.
module block_rms_meter
    import brm_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic        [RMS_BITS-1:0]    m_rms,
    input  logic                          cfg_wr_en,
    input  logic        [LEN_BITS-1:0]    cfg_wr_data
);

    // The sequencer walks one transaction through squaring, accumulation, the
    // block-end check and, at a block end, the root hand-off before it takes the next one.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_ACC   = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_ROOT  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [LEN_BITS-1:0]    blk_len_reg, blk_len_next;
    logic [LEN_BITS-1:0]    count_reg, count_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [MAG_BITS-1:0]    mag_reg, mag_next;
    logic [SQ_BITS-1:0]     prod_reg, prod_next;
    logic                   carry_reg, carry_next;
    logic                   m_valid_reg, m_valid_next;
    logic [RMS_BITS-1:0]    m_rms_reg, m_rms_next;

    logic [MAG_BITS-1:0]    sample_ext;
    logic [MAG_BITS-1:0]    sample_mag;
    logic [MAG_BITS:0]      part_sum;
    logic                   sum_bit;
    logic                   carry_out;
    logic [LEN_BITS-1:0]    len_eff;
    logic [LEN_BITS-1:0]    count_inc;
    logic                   block_end;
    logic                   out_free;

    brm_req_t               root_req;
    brm_rsp_t               root_rsp;
    logic [RMS_BITS-1:0]    root_value;

    brm_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (root_req),
        .rsp     (root_rsp),
        .sum     (sum_reg),
        .len     (len_eff),
        .root    (root_value)
    );

    always_comb begin
        // Magnitude of a Q1.15 sample; the most negative code gives 32768.
        sample_ext = {s_sample[SAMPLE_BITS-1], s_sample};
        sample_mag = s_sample[SAMPLE_BITS-1] ? (~sample_ext + 1'b1) : sample_ext;

        // Serial-parallel squarer: one multiplier bit per cycle, LSB first.
        part_sum = {1'b0, prod_reg[SQ_BITS-1:MAG_BITS]}
                 + (prod_reg[0] ? {1'b0, mag_reg} : '0);

        // Bit-serial adder for the running sum; the sum register rotates once.
        sum_bit   = sum_reg[0] ^ prod_reg[0] ^ carry_reg;
        carry_out = (sum_reg[0] & prod_reg[0]) | (carry_reg & (sum_reg[0] ^ prod_reg[0]));

        // A length of zero acts as one, anything above the maximum as the maximum.
        if (blk_len_reg == '0) begin
            len_eff = LEN_BITS'(1);
        end else if (blk_len_reg > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = blk_len_reg;
        end

        count_inc = count_reg + 1'b1;
        block_end = (count_inc >= len_eff);
        out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        blk_len_next = cfg_wr_en ? cfg_wr_data : blk_len_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        mag_next     = mag_reg;
        prod_next    = prod_reg;
        carry_next   = carry_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rms_next   = m_rms_reg;
        root_req     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mag_next   = sample_mag;
                    prod_next  = {{MAG_BITS{1'b0}}, sample_mag};
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next = {part_sum, prod_reg[MAG_BITS-1:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == MUL_LAST) begin
                    step_next  = '0;
                    carry_next = 1'b0;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                sum_next   = {sum_bit, sum_reg[SUM_BITS-1:1]};
                prod_next  = {1'b0, prod_reg[SQ_BITS-1:1]};
                carry_next = carry_out;
                step_next  = step_reg + 1'b1;
                if (step_reg == ACC_LAST) begin
                    // A carry out of the top bit means the sum overflowed: saturate.
                    if (carry_out) begin
                        sum_next = '1;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (block_end) begin
                    // The root unit may still hold the previous block's result.
                    if (!root_rsp.busy) begin
                        root_req.start = 1'b1;
                        sum_next       = '0;
                        count_next     = '0;
                        state_next     = ST_ROOT;
                    end
                end else begin
                    count_next = count_inc;
                    state_next = ST_IDLE;
                end
            end
            ST_ROOT: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The finished root moves to the output register once it is free.
        if (root_rsp.done && out_free) begin
            root_req.ack = 1'b1;
            m_valid_next = 1'b1;
            m_rms_next   = root_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            blk_len_reg <= LEN_RESET;
            count_reg   <= '0;
            sum_reg     <= '0;
            carry_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            blk_len_reg <= blk_len_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            carry_reg   <= carry_next;
            m_valid_reg <= m_valid_next;
        end
        mag_reg   <= mag_next;
        prod_reg  <= prod_next;
        m_rms_reg <= m_rms_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rms   = m_rms_reg;

    // The sample count is cleared at each block end and never reaches the maximum.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < LEN_MAX)
        else $error("sample count out of range");

    // The root unit is never started while it still works on or holds a block.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        root_req.start |-> !root_rsp.busy)
        else $error("root unit started while busy");

    // An accepted transaction always enters the squarer next.
    a_accept_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MUL))
        else $error("accepted sample did not enter the squarer");

    // A handed-over root appears at the output in the next cycle.
    a_root_out: assert property (@(posedge aclk) disable iff (!aresetn)
        root_req.ack |=> (m_valid && m_rms == $past(root_value)))
        else $error("root result not presented");

endmodule
